/* design/pma_pkg.sv */
// Package for the path metrics accumulator: widths, constants, command and status types.
// Used by pma_ctrl, pma_datapath, the top level and the bench; no dependencies.
package pma_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int ANGLE_BITS = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int GUARD      = 16;
    localparam int CW         = DIFF_W + GUARD + 3;   // CORDIC x/y width
    localparam int ZW         = ANGLE_BITS + 2;
    localparam int LEN_W      = 48;
    localparam int TURN_W     = 32;
    localparam int SQ_W       = 68;                   // sum of squares, two zero bits on top
    localparam int ROOT_W     = 33;
    localparam int REM_W      = ROOT_W + 3;
    localparam int STEP_W     = 5;
    // two squaring steps, then two root bits per step
    localparam int RUN_STEPS  = 2 + SQ_W / 4;

    typedef logic [ANGLE_BITS-1:0] angle_t;

    // Rounded atan(2^-i) in ANGLE_BITS binary angle units.
    function automatic angle_t atan_lut(input logic [STEP_W-1:0] i);
        logic [31:0] t;
        logic [32:0] r;
        begin
            case (i)
                5'd0:  t = 32'h20000000;
                5'd1:  t = 32'h12E4051E;
                5'd2:  t = 32'h09FB385B;
                5'd3:  t = 32'h051111D4;
                5'd4:  t = 32'h028B0D43;
                5'd5:  t = 32'h0145D7E1;
                5'd6:  t = 32'h00A2F61E;
                5'd7:  t = 32'h00517C55;
                5'd8:  t = 32'h0028BE53;
                5'd9:  t = 32'h00145F2F;
                5'd10: t = 32'h000A2F98;
                5'd11: t = 32'h000517CC;
                5'd12: t = 32'h00028BE6;
                5'd13: t = 32'h000145F3;
                5'd14: t = 32'h0000A2FA;
                5'd15: t = 32'h0000517D;
                default: t = 32'h0;
            endcase
            r = {1'b0, t} + (33'd1 << (31 - ANGLE_BITS));
            atan_lut = r[31 -: ANGLE_BITS];
        end
    endfunction

    typedef struct packed {
        logic load;     // capture differences, start CORDIC and root
        logic step;     // one iteration of both units
        logic commit;   // fold results into the sums
    } pma_cmd_t;

    typedef struct packed {
        logic last_step;
    } pma_stat_t;

endpackage

/* design/pma_if.sv */
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; payload type is a parameter of the interface.
interface pma_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/pma_ctrl.sv */
// Sequencer for the path metrics accumulator: accept, iterate, commit, present.
// Depends on pma_pkg.
module pma_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pma_pkg::pma_stat_t stat,
    output pma_pkg::pma_cmd_t  cmd
);
    import pma_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    // Decode commands and advance state
    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.last_step)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the commit while the previous beat still waits
                if (!ovalid_reg || out_ready)
                begin
                    cmd.commit  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

/* design/pma_datapath.sv */
// Datapath: previous point, CORDIC vectoring, bit-serial square root, saturating sums.
// Depends on pma_pkg.
module pma_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  pma_pkg::pma_cmd_t   cmd,
    output pma_pkg::pma_stat_t  stat,
    input  logic               start_path,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] heading,
    output logic [47:0]        path_length,
    output logic [31:0]        tangent_turn,
    output logic [31:0]        heading_turn,
    output logic               saturated
);
    import pma_pkg::*;

    logic [COORD_W-1:0]   px_reg, py_reg;
    logic [COORD_W-1:0]   nx_reg, ny_reg;
    angle_t               ptan_reg, phead_reg, head_reg;
    logic [1:0]           cnt_reg;
    logic                 start_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [TURN_W-1:0]    tsum_reg, hsum_reg;
    logic                 sat_reg;
    logic                 zero_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [STEP_W-1:0]    i_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [DIFF_W-1:0]    ax_reg, ay_reg;
    logic [1:0]           mul_ph_reg;

    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [CW-1:0]     x0, y0, sx, sy;
    logic signed [ZW-1:0]     z0;
    logic [1:0]               cnt_eff;
    angle_t                   ang;

    assign cnt_eff = start_path ? 2'd0 : cnt_reg;
    assign dx = DIFF_W'(pos_x) - DIFF_W'($signed(px_reg));
    assign dy = DIFF_W'(pos_y) - DIFF_W'($signed(py_reg));

    // Pre-rotate into the right half plane
    always_comb
    begin
        x0 = CW'(dx) <<< GUARD;
        y0 = CW'(dy) <<< GUARD;
        z0 = '0;
        if (dx[DIFF_W-1])
        begin
            if (!dy[DIFF_W-1])
            begin
                x0 = CW'(dy) <<< GUARD;
                y0 = -(CW'(dx) <<< GUARD);
                z0 = ZW'(1) <<< (ANGLE_BITS - 2);
            end
            else
            begin
                x0 = -(CW'(dy) <<< GUARD);
                y0 = CW'(dx) <<< GUARD;
                z0 = -(ZW'(1) <<< (ANGLE_BITS - 2));
            end
        end
    end

    assign sx = x_reg >>> i_reg;
    assign sy = y_reg >>> i_reg;
    assign ang = atan_lut(i_reg);
    assign stat.last_step = (i_reg == STEP_W'(RUN_STEPS - 1));

    // Square root step: two radicand pairs per cycle, 34 pairs over 17 steps
    // (the radicand carries two zero bits on top, so the count of pairs is even)
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_sh2, trial2;
    logic [ROOT_W-1:0] root1;
    logic [REM_W-1:0]  rem1;
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], sq_reg[SQ_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        if (rem_sh >= trial)
        begin
            rem1  = rem_sh - trial;
            root1 = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem1  = rem_sh;
            root1 = {root_reg[ROOT_W-2:0], 1'b0};
        end
        rem_sh2 = {rem1[REM_W-3:0], sq_reg[SQ_W-3 -: 2]};
        trial2  = {1'b0, root1, 2'b01};
    end

    // Wrapped absolute angle difference
    function automatic angle_t abs_wrap(input angle_t a, input angle_t b);
        angle_t d;
        begin
            d = a - b;
            abs_wrap = d[ANGLE_BITS-1] ? angle_t'(-d) : d;
        end
    endfunction

    logic [LEN_W:0]  len_n;
    logic [TURN_W:0] tsum_n, hsum_n;
    logic            len_ovf, hsum_ovf, tsum_ovf;
    angle_t          tan_fin;
    assign tan_fin = zero_reg ? '0 : z_reg[ANGLE_BITS-1:0];
    assign len_n  = {1'b0, len_reg} + (LEN_W+1)'(root_reg);
    assign hsum_n = {1'b0, hsum_reg} + (TURN_W+1)'(abs_wrap(head_reg, phead_reg));
    assign tsum_n = {1'b0, tsum_reg} + (TURN_W+1)'(abs_wrap(tan_fin, ptan_reg));
    assign len_ovf  = (len_n >= (LEN_W+1)'({LEN_W{1'b1}}));
    assign hsum_ovf = (hsum_n >= (TURN_W+1)'({TURN_W{1'b1}}));
    assign tsum_ovf = (tsum_n >= (TURN_W+1)'({TURN_W{1'b1}}));

    // Control-side state; sums change only at commit so a waiting beat holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            start_reg <= 1'b0;
            len_reg  <= '0;
            tsum_reg <= '0;
            hsum_reg <= '0;
            sat_reg  <= 1'b0;
            px_reg   <= '0;
            py_reg   <= '0;
            ptan_reg <= '0;
            phead_reg <= '0;
        end
        else if (cmd.load)
        begin
            start_reg <= start_path;
            cnt_reg   <= cnt_eff;
        end
        else if (cmd.commit)
        begin
            if (start_reg)
            begin
                len_reg  <= '0;
                tsum_reg <= '0;
                hsum_reg <= '0;
                sat_reg  <= 1'b0;
            end
            else if (cnt_reg != 2'd0)
            begin
                len_reg  <= len_ovf ? '1 : len_n[LEN_W-1:0];
                hsum_reg <= hsum_ovf ? '1 : hsum_n[TURN_W-1:0];
                if (cnt_reg == 2'd2)
                    tsum_reg <= tsum_ovf ? '1 : tsum_n[TURN_W-1:0];
                sat_reg  <= sat_reg | len_ovf | hsum_ovf | ((cnt_reg == 2'd2) & tsum_ovf);
                ptan_reg <= tan_fin;
            end
            if (cnt_reg != 2'd2)
                cnt_reg <= cnt_reg + 2'd1;
            px_reg    <= nx_reg;
            py_reg    <= ny_reg;
            phead_reg <= head_reg;
        end
    end

    // Iterative units: CORDIC and square root share the step counter
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= z0;
            i_reg    <= '0;
            zero_reg <= (dx == '0) && (dy == '0);
            ax_reg   <= dx[DIFF_W-1] ? DIFF_W'(-dx) : dx;
            ay_reg   <= dy[DIFF_W-1] ? DIFF_W'(-dy) : dy;
            nx_reg   <= pos_x;
            ny_reg   <= pos_y;
            head_reg <= heading;
            rem_reg  <= '0;
            root_reg <= '0;
            mul_ph_reg <= '0;
            sq_reg   <= '0;
        end
        else if (cmd.step)
        begin
            // rotate during the CORDIC steps only; later steps serve the root
            if (i_reg < STEP_W'(CORDIC_STEPS))
            begin
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + sy;
                    y_reg <= y_reg - sx;
                    z_reg <= z_reg + ZW'(ang);
                end
                else
                begin
                    x_reg <= x_reg - sy;
                    y_reg <= y_reg + sx;
                    z_reg <= z_reg - ZW'(ang);
                end
            end
            i_reg <= i_reg + 1'b1;
            // squares take the first two steps; the root the following ones
            if (mul_ph_reg == 2'd0)
            begin
                sq_reg     <= SQ_W'(ax_reg * ax_reg);
                mul_ph_reg <= 2'd1;
            end
            else if (mul_ph_reg == 2'd1)
            begin
                sq_reg     <= sq_reg + SQ_W'(ay_reg * ay_reg);
                mul_ph_reg <= 2'd2;
            end
            else
            begin
                if (rem_sh2 >= trial2)
                begin
                    rem_reg  <= rem_sh2 - trial2;
                    root_reg <= {root1[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh2;
                    root_reg <= {root1[ROOT_W-2:0], 1'b0};
                end
                sq_reg <= sq_reg << 4;
            end
        end
    end

    assign path_length  = len_reg;
    assign tangent_turn = tsum_reg;
    assign heading_turn = hsum_reg;
    assign saturated    = sat_reg;
endmodule

/* design/path_metrics_accumulator_top.sv */
// Path metrics accumulator top level.
// An accepted waypoint goes through load, 19 steps (two squaring steps, then 17 square
// root steps, the 16 CORDIC steps run alongside) and commit to give its result beat.
// A new waypoint is taken only after commit; a result beat left waiting holds the commit.
// Reset (rst_n, asynchronous) clears sums, point count, flag and previous point.
// Depends on pma_pkg, pma_if, pma_ctrl and pma_datapath.
module path_metrics_accumulator_top (
    input logic clk,
    input logic rst_n,
    pma_if.sink   in_ch,
    pma_if.source out_ch
);
    import pma_pkg::*;

    pma_cmd_t  cmd;
    pma_stat_t stat;

    pma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pma_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .start_path   (in_ch.data.start_path),
        .pos_x        (in_ch.data.pos_x),
        .pos_y        (in_ch.data.pos_y),
        .heading      (in_ch.data.heading),
        .path_length  (out_ch.data.path_length),
        .tangent_turn (out_ch.data.tangent_turn),
        .heading_turn (out_ch.data.heading_turn),
        .saturated    (out_ch.data.saturated)
    );

    // A waiting result beat holds valid and data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result beat changed while waiting");
    // Commit raises the output valid next cycle
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_ch.valid) else $error("commit without result");
    // Load and commit never coincide
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.commit)) else $error("load and commit together");
endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for path_metrics_accumulator_top: directed waypoint table, then random paths.
// A waypoint predictor models segment length, tangent and heading sums; depends on pma_pkg, pma_if.
`timescale 1ns / 100ps

module testbench;

    import pma_pkg::*;

    typedef struct packed {
        logic               start_path;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
    } waypoint_t;

    typedef struct packed {
        logic [LEN_W-1:0]  path_length;
        logic [TURN_W-1:0] tangent_turn;
        logic [TURN_W-1:0] heading_turn;
        logic              saturated;
    } metrics_t;

    typedef struct packed {
        logic      known;
        waypoint_t wp;
        metrics_t  sums;
    } path_row_t;

    localparam logic signed [31:0] XMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] XMIN = 32'sh80000000;
    localparam logic [LEN_W-1:0]   LEN_TOP  = '1;
    localparam logic [TURN_W-1:0]  TURN_TOP = '1;
    localparam int                 IDLE_LIMIT = 5000;

    localparam int N_ROWS = 18;
    localparam path_row_t PATH_TABLE [N_ROWS] = '{
        '{1'b1, '{1'b0, 32'sd0, 32'sd0, 16'sd0}, '{48'd0, 32'd0, 32'd0, 1'b0}},
        '{1'b1, '{1'b0, 32'sh10000, 32'sd0, 16'sh4000}, '{48'h10000, 32'd0, 32'h4000, 1'b0}},
        '{1'b0, '{1'b0, 32'sh10000, 32'sh10000, -16'sd32768}, '0},
        '{1'b0, '{1'b0, 32'sh10000, 32'sh10000, -16'sd32768}, '0},
        '{1'b0, '{1'b0, XMAX, XMAX, 16'sh7FFF}, '0},
        '{1'b0, '{1'b0, XMIN, XMIN, -16'sd32768}, '0},
        '{1'b0, '{1'b0, XMIN, XMAX, 16'sd0}, '0},
        '{1'b0, '{1'b0, XMAX, XMIN, -16'sd1}, '0},
        '{1'b1, '{1'b1, 32'sd5, 32'sd5, 16'sh1234}, '{48'd0, 32'd0, 32'd0, 1'b0}},
        '{1'b1, '{1'b1, -32'sd1, -32'sd1, 16'sh5555}, '{48'd0, 32'd0, 32'd0, 1'b0}},
        '{1'b0, '{1'b0, -32'sh10001, -32'sd1, -16'sh5556}, '0},
        '{1'b0, '{1'b0, -32'sh10001, -32'sh20001, 16'sd1}, '0},
        '{1'b0, '{1'b0, 32'sh30000, -32'sh20001, 16'sd0}, '0},
        '{1'b0, '{1'b0, 32'sh30000, 32'sh50000, 16'sd1}, '0},
        '{1'b0, '{1'b0, -32'sh70000, 32'sh50000, -16'sd2}, '0},
        '{1'b0, '{1'b0, -32'sh70000, 32'sh50003, 16'sh2AAA}, '0},
        '{1'b1, '{1'b1, XMAX, XMIN, 16'sh7FFF}, '{48'd0, 32'd0, 32'd0, 1'b0}},
        '{1'b0, '{1'b0, XMIN, XMAX, 16'sh0F0F}, '0}
    };

    // atan(2^-i) as a fraction of a full turn, times 2^32
    localparam logic [31:0] ATAN_TURN [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pma_if #(.payload_t(waypoint_t)) wp_ch ();
    pma_if #(.payload_t(metrics_t))  sum_ch ();

    path_metrics_accumulator_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (wp_ch.sink),
        .out_ch (sum_ch.source)
    );

    always #2 clk = ~clk;

    // predictor state
    logic signed [31:0] last_x = '0, last_y = '0;
    angle_t             last_tangent = '0, last_heading = '0;
    int                 points_seen = 0;
    logic [LEN_W-1:0]   length_acc = '0;
    logic [TURN_W-1:0]  tangent_acc = '0, heading_acc = '0;
    logic               sat_seen = 1'b0;

    metrics_t expected_sums[$];
    int       error_count = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;

    function automatic logic [32:0] floor_root(input logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] root;
        logic [67:0] trial;
        rem = '0;
        root = '0;
        for (int k = 32; k >= 0; k--)
        begin
            rem = (rem << 2) | v[2*k +: 2];
            trial = (root << 2) | 68'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 68'd1;
            end
            else
                root = root << 1;
        end
        return root[32:0];
    endfunction

    // CORDIC vectoring angle of the segment, binary angle units
    function automatic angle_t segment_angle(input longint dx, input longint dy);
        longint x, y, z, t, sx, sy, a;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (dx == 0 && dy == 0)
            return '0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 1 << (ANGLE_BITS - 2);
            end
            else
            begin
                x = -y; y = t; z = -(1 << (ANGLE_BITS - 2));
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            a = longint'((64'(ATAN_TURN[i]) + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS));
            sx = x >>> i;
            sy = y >>> i;
            if (y >= 0)
            begin
                x = x + sy; y = y - sx; z = z + a;
            end
            else
            begin
                x = x - sy; y = y + sx; z = z - a;
            end
        end
        return angle_t'(z);
    endfunction

    function automatic angle_t turn_size(input angle_t a, input angle_t b);
        angle_t d;
        d = a - b;
        if (d[ANGLE_BITS-1])
            d = -d;
        return d;
    endfunction

    function automatic logic [TURN_W-1:0] add_turn(input logic [TURN_W-1:0] s, input angle_t inc);
        logic [TURN_W:0] n;
        n = s + inc;
        if (n >= TURN_TOP)
        begin
            sat_seen = 1'b1;
            return TURN_TOP;
        end
        return n[TURN_W-1:0];
    endfunction

    // fold one waypoint into the running path sums
    function automatic metrics_t advance_path(input waypoint_t w);
        longint         dx, dy;
        logic [65:0]    ax, ay;
        logic [LEN_W:0] n;
        angle_t         tan;
        if (w.start_path)
        begin
            length_acc = '0; tangent_acc = '0; heading_acc = '0;
            points_seen = 0; sat_seen = 1'b0;
        end
        if (points_seen > 0)
        begin
            dx = longint'(w.pos_x) - longint'(last_x);
            dy = longint'(w.pos_y) - longint'(last_y);
            ax = 66'(dx < 0 ? -dx : dx);
            ay = 66'(dy < 0 ? -dy : dy);
            tan = segment_angle(dx, dy);
            n = length_acc + floor_root(ax * ax + ay * ay);
            if (n >= LEN_TOP)
            begin
                sat_seen = 1'b1;
                length_acc = LEN_TOP;
            end
            else
                length_acc = n[LEN_W-1:0];
            heading_acc = add_turn(heading_acc, turn_size(w.heading, last_heading));
            if (points_seen > 1)
                tangent_acc = add_turn(tangent_acc, turn_size(tan, last_tangent));
            last_tangent = tan;
        end
        if (points_seen < 2)
            points_seen++;
        last_x = w.pos_x;
        last_y = w.pos_y;
        last_heading = w.heading;
        return '{length_acc, tangent_acc, heading_acc, sat_seen};
    endfunction

    // present one waypoint, idle between bursts, record its prediction on acceptance
    task automatic send_waypoint(input waypoint_t w, input bit known, input metrics_t fixed);
        metrics_t m;
        if (burst_left == 0)
        begin
            wp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        wp_ch.valid <= 1'b1;
        wp_ch.data  <= w;
        @(posedge clk);
        while (!wp_ch.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        m = advance_path(w);
        if (known && m != fixed)
        begin
            $error("table row disagrees with predictor: %h vs %h", fixed, m);
            error_count++;
        end
        expected_sums.insert(expected_sums.size(), m);
    endtask

    function automatic logic signed [31:0] any_coord();
        case ($urandom_range(0, 3))
            0: return XMAX;
            1: return XMIN;
            default: return $urandom;
        endcase
    endfunction

    // receiver: windows of free flow alternating with random stalls
    int stall_window = 0;
    bit stall_mode = 1'b0;
    always @(posedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_mode <= ~stall_mode;
            stall_window <= $urandom_range(5, 60);
        end
        else
            stall_window <= stall_window - 1;
        if (!rst_n)
            sum_ch.ready <= 1'b0;
        else
            sum_ch.ready <= !stall_mode || ($urandom_range(0, 2) == 0);
    end

    // check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        metrics_t exp_m;
        if (rst_n && sum_ch.valid && sum_ch.ready)
        begin
            if (expected_sums.size() == 0)
            begin
                $error("result beat with nothing expected: %h", sum_ch.data);
                error_count++;
            end
            else
            begin
                exp_m = expected_sums.pop_front();
                if (sum_ch.data.path_length !== exp_m.path_length)
                begin
                    $error("path_length exp %0d got %0d", exp_m.path_length,
                           sum_ch.data.path_length);
                    error_count++;
                end
                if (sum_ch.data.tangent_turn !== exp_m.tangent_turn)
                begin
                    $error("tangent_turn exp %0d got %0d", exp_m.tangent_turn,
                           sum_ch.data.tangent_turn);
                    error_count++;
                end
                if (sum_ch.data.heading_turn !== exp_m.heading_turn)
                begin
                    $error("heading_turn exp %0d got %0d", exp_m.heading_turn,
                           sum_ch.data.heading_turn);
                    error_count++;
                end
                if (sum_ch.data.saturated !== exp_m.saturated)
                begin
                    $error("saturated exp %0b got %0b", exp_m.saturated, sum_ch.data.saturated);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((wp_ch.valid && wp_ch.ready) || (sum_ch.valid && sum_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** path_metrics_accumulator_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        waypoint_t w;
        int        seg_count;
        wp_ch.valid <= 1'b0;
        wp_ch.data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int r = 0; r < N_ROWS; r++)
            send_waypoint(PATH_TABLE[r].wp, PATH_TABLE[r].known, PATH_TABLE[r].sums);

        // random paths: mostly short hops, some far jumps and extremes
        for (int n = 0; n < 2000; n += seg_count)
        begin
            seg_count = $urandom_range(1, 30);
            for (int k = 0; k < seg_count; k++)
            begin
                w.start_path = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 60) == 0);
                case ($urandom_range(0, 9))
                    0:       begin w.pos_x = any_coord(); w.pos_y = any_coord(); end
                    1:       begin w.pos_x = last_x; w.pos_y = last_y; end
                    2:       begin w.pos_x = $urandom; w.pos_y = $urandom; end
                    default:
                    begin
                        w.pos_x = last_x + $signed(32'($urandom_range(0, 32'h3FFFF)) - 32'h20000);
                        w.pos_y = last_y + $signed(32'($urandom_range(0, 32'h3FFFF)) - 32'h20000);
                    end
                endcase
                w.heading = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                          : last_heading + 16'($urandom_range(0, 8192)) - 16'sd4096;
                send_waypoint(w, 1'b0, '0);
            end
        end

        w = '{1'b1, 32'sd7, -32'sd7, 16'sd9};
        send_waypoint(w, 1'b1, '{48'd0, 32'd0, 32'd0, 1'b0});
        wp_ch.valid <= 1'b0;

        // drain, then allow the pipeline to settle
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("** path_metrics_accumulator_top: PASSED **");
        else
            $display("** path_metrics_accumulator_top: FAILED **");
        $finish;
    end

endmodule
